>>> sv/pcsh_pkg.sv
// ----------------------------------------------------------------------------
// pcsh_pkg
// Shared types and constants for the PC-sample histogram.
// ----------------------------------------------------------------------------
package pcsh_pkg;

    // Histogram size and index width
    localparam int DEPTH = 4096;
    localparam int IDX_W = $clog2(DEPTH);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    // Register reset values
    localparam logic [31:0] RESET_CODE_BASE = 32'h0000_8000;
    localparam logic [31:0] RESET_CODE_END  = 32'h0000_C000;
    localparam logic [31:0] RESET_DUMP_MIN  = 32'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_CODE_BASE = 2'd0;
    localparam logic [1:0] REG_CODE_END  = 2'd1;
    localparam logic [1:0] REG_DUMP_MIN  = 2'd2;

    // Item function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // Command kinds handed from front to back
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_OOR    = 2'd2;

    typedef struct packed {
        logic        func;
        logic [31:0] pc;
        logic [11:0] entry_index;
    } in_word_t;

    typedef struct packed {
        logic [31:0] entry_addr;
        logic [31:0] entry_count;
        logic        above_min;
        logic        out_of_range;
    } out_word_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] idx;
        logic [31:0]      addr;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

>>> sv/pcsh_front.sv
// ----------------------------------------------------------------------------
// pcsh_front
// Configuration registers and item classification into back-end commands.
// ----------------------------------------------------------------------------
module pcsh_front
    import pcsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [31:0] cfg_wdata,
    input  in_word_t    item,
    output cmd_t        cmd,
    output logic [31:0] dump_min
);

    logic [31:0] code_base_reg, code_base_next;
    logic [31:0] code_end_reg,  code_end_next;
    logic [31:0] dump_min_reg,  dump_min_next;

    logic [31:0] off;
    logic [31:0] slot;
    logic        below;
    logic        past;
    logic        slot_ok;
    logic [1:0]  align;
    logic [31:0] sample_addr;
    logic [31:0] ei_ext;
    logic [31:0] read_addr;
    logic        ei_ok;
    logic        sample_ok;

    always_comb
    begin
        code_base_next = code_base_reg;
        code_end_next  = code_end_reg;
        dump_min_next  = dump_min_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_CODE_BASE: code_base_next = cfg_wdata;
                REG_CODE_END:  code_end_next  = cfg_wdata;
                REG_DUMP_MIN:  dump_min_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_base_reg <= RESET_CODE_BASE;
            code_end_reg  <= RESET_CODE_END;
            dump_min_reg  <= RESET_DUMP_MIN;
        end
        else
        begin
            code_base_reg <= code_base_next;
            code_end_reg  <= code_end_next;
            dump_min_reg  <= dump_min_next;
        end
    end

    assign dump_min = dump_min_reg;

    // sample path
    assign off       = item.pc - code_base_reg;
    assign slot      = {2'b00, off[31:2]};
    assign below     = item.pc < code_base_reg;
    assign past      = item.pc >= code_end_reg;
    assign slot_ok   = slot < 32'(DEPTH);
    assign sample_ok = !below && !past && slot_ok;
    // base + slot*4 equals pc less the misaligned part of the offset
    assign align       = item.pc[1:0] - code_base_reg[1:0];
    assign sample_addr = item.pc - {30'b0, align};

    // read path
    assign ei_ext    = 32'(item.entry_index);
    assign read_addr = code_base_reg + {ei_ext[29:0], 2'b00};
    assign ei_ok     = ei_ext < 32'(DEPTH);

    always_comb
    begin
        if (item.func == FUNC_READ)
        begin
            cmd.kind = ei_ok ? CMD_READ : CMD_OOR;
            cmd.idx  = ei_ext[IDX_W-1:0];
            cmd.addr = read_addr;
        end
        else
        begin
            cmd.kind = sample_ok ? CMD_SAMPLE : CMD_OOR;
            cmd.idx  = slot[IDX_W-1:0];
            cmd.addr = sample_ok ? sample_addr : 32'd0;
        end
    end

endmodule

>>> sv/pcsh_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pcsh_cmd_fifo
// Short command queue decoupling the front from the back.
// ----------------------------------------------------------------------------
module pcsh_cmd_fifo
    import pcsh_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  cmd_t      wr_cmd,
    input  logic      rd_en,
    output cmd_t      rd_cmd,
    output q_status_t status
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_PTR_W:0]   cnt_reg,    cnt_next;
    logic                  do_wr;
    logic                  do_rd;

    assign status.full  = cnt_reg == (CMDQ_PTR_W+1)'(CMDQ_DEPTH);
    assign status.empty = cnt_reg == '0;
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_cmd       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

>>> sv/pcsh_back.sv
// ----------------------------------------------------------------------------
// pcsh_back
// Counter store, read-modify-write sequencer and result register.
// ----------------------------------------------------------------------------
module pcsh_back
    import pcsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_status_t   cmdq,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    input  logic [31:0] dump_min,
    output logic        clearing,
    output out_word_t   result,
    output logic        empty,
    input  logic        pop
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [31:0]      mem [DEPTH];
    logic [31:0]      rd_data_reg;

    logic [1:0]       state_reg,   state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    cmd_t             cur_reg;
    out_word_t        res_reg,     res_next;
    logic             res_valid_reg, res_valid_next;

    logic             res_free;
    logic             start;
    logic             valid;
    logic [31:0]      count;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;

    assign res_free = !res_valid_reg || pop;
    assign start    = (state_reg == ST_IDLE) && !cmdq.empty && res_free;
    assign cmd_pop  = start;
    assign clearing = state_reg == ST_CLEAR;
    assign empty    = !res_valid_reg;
    assign result   = res_reg;

    assign valid = cur_reg.kind != CMD_OOR;
    assign count = (cur_reg.kind == CMD_SAMPLE) ? rd_data_reg + 32'd1 : rd_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(DEPTH-1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                res_next.entry_addr   = cur_reg.addr;
                res_next.entry_count  = valid ? count : 32'd0;
                res_next.above_min    = valid && (count > dump_min);
                res_next.out_of_range = !valid;
                res_valid_next        = 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (start)
        begin
            cur_reg <= cmd;
        end
    end

    // store: zeroed by the sweep after reset, else written back on a sample
    assign mem_we    = clearing || ((state_reg == ST_LOOK) && (cur_reg.kind == CMD_SAMPLE));
    assign mem_waddr = clearing ? clr_cnt_reg : cur_reg.idx;
    assign mem_wdata = clearing ? 32'd0 : count;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (start)
        begin
            rd_data_reg <= mem[cmd.idx];
        end
    end

endmodule

>>> sv/pc_sample_histogram.sv
// ----------------------------------------------------------------------------
// pc_sample_histogram
// Histogram of sampled program counters, one 32-bit counter per word slot.
//
// Items go in through push/full as item words: a sample (func 0) bumps the
// counter of the slot holding pc, a read (func 1) returns entry_index's
// count. Every item gives exactly one result word on result/empty/pop.
// Registers code_base, code_end and dump_min are written through cfg_we,
// cfg_idx and cfg_wdata; the user must do so only while the block is idle,
// which the block itself does not enforce. An item passes the command queue,
// the counter read register and the result register; the back end reads and
// writes back one item at a time through the single counter memory port pair.
// A two-word command queue sits between classification and the counter
// update, so the input keeps taking words while a result waits for pop;
// when the receiver stalls, the queue fills and full rises.
// After reset all 4096 entries of the counter store are swept to zero, one
// entry per cycle; full stays high during the sweep.
// ----------------------------------------------------------------------------
module pc_sample_histogram
    import pcsh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  in_word_t    item,
    output logic        empty,
    input  logic        pop,
    output out_word_t   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [31:0] cfg_wdata
);

    cmd_t        front_cmd;
    cmd_t        queued_cmd;
    q_status_t   cmdq;
    logic        cmd_pop;
    logic        clearing;
    logic [31:0] dump_min;

    assign full = cmdq.full || clearing;

    pcsh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .cmd       (front_cmd),
        .dump_min  (dump_min)
    );

    pcsh_cmd_fifo u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push && !full),
        .wr_cmd (front_cmd),
        .rd_en  (cmd_pop),
        .rd_cmd (queued_cmd),
        .status (cmdq)
    );

    pcsh_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmdq     (cmdq),
        .cmd      (queued_cmd),
        .cmd_pop  (cmd_pop),
        .dump_min (dump_min),
        .clearing (clearing),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule
